// File: rtl/core/tcc_pkg.sv
// ----------------------------------------------------------------------------
// tcc_pkg
// Shared types and constants of the touch coordinate calibrator.
// ----------------------------------------------------------------------------
`default_nettype none

package tcc_pkg;

	localparam int unsigned FieldW  = 16;
	localparam int unsigned CoefW   = 32;
	localparam int unsigned DiffW   = 33;
	localparam int unsigned ProdW   = CoefW + DiffW;
	localparam int unsigned FracW   = 22;
	localparam int unsigned CfgIdxW = 3;

	localparam logic [FieldW-1:0] XLimit = 16'h00ff;
	localparam logic [FieldW-1:0] YLimit = 16'h00bf;

	typedef enum logic [CfgIdxW-1:0] {
		REG_CALIB_ENABLE = 3'd0,
		REG_X_OFFSET     = 3'd1,
		REG_X_GAIN       = 3'd2,
		REG_Y_OFFSET     = 3'd3,
		REG_Y_GAIN       = 3'd4
	} cfg_reg_t;

	typedef enum logic [1:0] {
		MODE_PASS = 2'd0,
		MODE_ZERO = 2'd1,
		MODE_CAL  = 2'd2
	} mode_t;

	typedef struct packed {
		logic [CoefW-1:0] x_offset;
		logic [CoefW-1:0] x_gain;
		logic [CoefW-1:0] y_offset;
		logic [CoefW-1:0] y_gain;
		logic             calib_enable;
	} cfg_t;

	typedef struct packed {
		mode_t             mode;
		logic [FieldW-1:0] raw_x;
		logic [FieldW-1:0] raw_y;
		logic [FieldW-1:0] flags;
		logic [FieldW-1:0] extra;
		logic [DiffW-1:0]  diff_x;
		logic [DiffW-1:0]  diff_y;
	} s1_t;

	typedef struct packed {
		mode_t             mode;
		logic [FieldW-1:0] raw_x;
		logic [FieldW-1:0] raw_y;
		logic [FieldW-1:0] flags;
		logic [FieldW-1:0] extra;
		logic [FieldW-1:0] scaled_x;
		logic [FieldW-1:0] scaled_y;
	} s2_t;

	typedef struct packed {
		logic [FieldW-1:0] screen_x;
		logic [FieldW-1:0] screen_y;
		logic [FieldW-1:0] flags_out;
		logic [FieldW-1:0] extra_out;
	} s3_t;

endpackage

`default_nettype wire

// File: rtl/core/tcc_if.sv
// ----------------------------------------------------------------------------
// tcc_if
// Valid/ready channels for raw touch records and calibrated results.
// ----------------------------------------------------------------------------
`default_nettype none

interface tcc_in_if;
	logic                          valid;
	logic                          ready;
	logic [tcc_pkg::FieldW-1:0]    raw_x;
	logic [tcc_pkg::FieldW-1:0]    raw_y;
	logic [tcc_pkg::FieldW-1:0]    touch_flags;
	logic [tcc_pkg::FieldW-1:0]    extra_word;

	modport source (output valid, raw_x, raw_y, touch_flags, extra_word, input ready);
	modport sink (input valid, raw_x, raw_y, touch_flags, extra_word, output ready);
endinterface

interface tcc_out_if;
	logic                          valid;
	logic                          ready;
	logic [tcc_pkg::FieldW-1:0]    screen_x;
	logic [tcc_pkg::FieldW-1:0]    screen_y;
	logic [tcc_pkg::FieldW-1:0]    flags_out;
	logic [tcc_pkg::FieldW-1:0]    extra_out;

	modport source (output valid, screen_x, screen_y, flags_out, extra_out, input ready);
	modport sink (input valid, screen_x, screen_y, flags_out, extra_out, output ready);
endinterface

`default_nettype wire

// File: rtl/core/tcc_front.sv
// ----------------------------------------------------------------------------
// tcc_front
// First stage: selects the mode and forms the offset-corrected raw values.
// ----------------------------------------------------------------------------
`default_nettype none

module tcc_front (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       advance,
	input  wire logic                       valid,
	input  wire logic [tcc_pkg::FieldW-1:0] raw_x,
	input  wire logic [tcc_pkg::FieldW-1:0] raw_y,
	input  wire logic [tcc_pkg::FieldW-1:0] touch_flags,
	input  wire logic [tcc_pkg::FieldW-1:0] extra_word,
	input  wire tcc_pkg::cfg_t              cfg,
	output logic                            valid_s1,
	output tcc_pkg::s1_t                    data_s1
);

	tcc_pkg::s1_t next_s1;

	always_comb begin
		if (!cfg.calib_enable) begin
			next_s1.mode = tcc_pkg::MODE_PASS;
		end else if (touch_flags == '0) begin
			next_s1.mode = tcc_pkg::MODE_ZERO;
		end else begin
			next_s1.mode = tcc_pkg::MODE_CAL;
		end
		next_s1.raw_x  = raw_x;
		next_s1.raw_y  = raw_y;
		next_s1.flags  = touch_flags;
		next_s1.extra  = extra_word;
		next_s1.diff_x = {{(tcc_pkg::DiffW-tcc_pkg::FieldW-2){1'b0}}, raw_x, 2'b00}
			- {cfg.x_offset[tcc_pkg::CoefW-1], cfg.x_offset};
		next_s1.diff_y = {{(tcc_pkg::DiffW-tcc_pkg::FieldW-2){1'b0}}, raw_y, 2'b00}
			- {cfg.y_offset[tcc_pkg::CoefW-1], cfg.y_offset};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (advance) begin
			valid_s1 <= valid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid) begin
			data_s1 <= next_s1;
		end
	end

endmodule

`default_nettype wire

// File: rtl/core/tcc_mul.sv
// ----------------------------------------------------------------------------
// tcc_mul
// Second stage: multiplies each corrected value by its gain and keeps the
// sixteen bits above the fraction.
// ----------------------------------------------------------------------------
`default_nettype none

module tcc_mul (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              advance,
	input  wire logic              valid_s1,
	input  wire tcc_pkg::s1_t      data_s1,
	input  wire tcc_pkg::cfg_t     cfg,
	output logic                   valid_s2,
	output tcc_pkg::s2_t           data_s2
);

	logic signed [tcc_pkg::ProdW-1:0] prod_x;
	logic signed [tcc_pkg::ProdW-1:0] prod_y;

	assign prod_x = $signed(cfg.x_gain) * $signed(data_s1.diff_x);
	assign prod_y = $signed(cfg.y_gain) * $signed(data_s1.diff_y);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1) begin
			data_s2.mode     <= data_s1.mode;
			data_s2.raw_x    <= data_s1.raw_x;
			data_s2.raw_y    <= data_s1.raw_y;
			data_s2.flags    <= data_s1.flags;
			data_s2.extra    <= data_s1.extra;
			data_s2.scaled_x <= prod_x[tcc_pkg::FracW +: tcc_pkg::FieldW];
			data_s2.scaled_y <= prod_y[tcc_pkg::FracW +: tcc_pkg::FieldW];
		end
	end

endmodule

`default_nettype wire

// File: rtl/core/tcc_clamp.sv
// ----------------------------------------------------------------------------
// tcc_clamp
// Third stage: clamps each axis to the screen and selects the final result.
// This stage is the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module tcc_clamp (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              advance,
	input  wire logic              valid_s2,
	input  wire tcc_pkg::s2_t      data_s2,
	output logic                   valid_s3,
	output tcc_pkg::s3_t           data_s3
);

	logic [tcc_pkg::FieldW-1:0] clamp_x;
	logic [tcc_pkg::FieldW-1:0] clamp_y;
	tcc_pkg::s3_t               next_s3;

	always_comb begin
		if (data_s2.scaled_x[tcc_pkg::FieldW-1]) begin
			clamp_x = '0;
		end else if (data_s2.scaled_x > tcc_pkg::XLimit) begin
			clamp_x = tcc_pkg::XLimit;
		end else begin
			clamp_x = data_s2.scaled_x;
		end
		if (data_s2.scaled_y[tcc_pkg::FieldW-1]) begin
			clamp_y = '0;
		end else if (data_s2.scaled_y > tcc_pkg::YLimit) begin
			clamp_y = tcc_pkg::YLimit;
		end else begin
			clamp_y = data_s2.scaled_y;
		end
	end

	always_comb begin
		next_s3.flags_out = data_s2.flags;
		next_s3.extra_out = data_s2.extra;
		case (data_s2.mode)
			tcc_pkg::MODE_PASS: begin
				next_s3.screen_x = data_s2.raw_x;
				next_s3.screen_y = data_s2.raw_y;
			end
			tcc_pkg::MODE_CAL: begin
				next_s3.screen_x = clamp_x;
				next_s3.screen_y = clamp_y;
			end
			default: begin
				next_s3.screen_x = '0;
				next_s3.screen_y = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (advance) begin
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s2) begin
			data_s3 <= next_s3;
		end
	end

endmodule

`default_nettype wire

// File: rtl/core/touch_coordinate_calibrator.sv
// ----------------------------------------------------------------------------
// touch_coordinate_calibrator
// Maps raw touch-panel records to screen coordinates by a linear calibration.
//
// Requests arrive on in_ch (raw X, raw Y, touch flags, extra word) and each
// gives exactly one result on out_ch, in order. The user must write the
// calibration registers through cfg_we / cfg_index / cfg_data only while
// the block is idle; the block itself does not enforce this. Correction,
// multiplication and clamping each take one register stage, and the last
// stage is the output register. Throughput is one request per cycle unless
// out_ch.ready is held low; then the stages stop filling from the output
// backward, and in_ch.ready stays high while any stage has room.
// Reset empties the pipeline and clears all calibration registers, which
// leaves calibration disabled.
// ----------------------------------------------------------------------------
`default_nettype none

module touch_coordinate_calibrator (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	tcc_in_if.sink                           in_ch,
	tcc_out_if.source                        out_ch,
	input  wire logic                        cfg_we,
	input  wire logic [tcc_pkg::CfgIdxW-1:0] cfg_index,
	input  wire logic [tcc_pkg::CoefW-1:0]   cfg_data
);

	tcc_pkg::cfg_t cfg_q;
	logic          valid_s1;
	logic          valid_s2;
	logic          valid_s3;
	tcc_pkg::s1_t  data_s1;
	tcc_pkg::s2_t  data_s2;
	tcc_pkg::s3_t  data_s3;
	logic          adv1;
	logic          adv2;
	logic          adv3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				tcc_pkg::REG_CALIB_ENABLE: cfg_q.calib_enable <= cfg_data[0];
				tcc_pkg::REG_X_OFFSET:     cfg_q.x_offset     <= cfg_data;
				tcc_pkg::REG_X_GAIN:       cfg_q.x_gain       <= cfg_data;
				tcc_pkg::REG_Y_OFFSET:     cfg_q.y_offset     <= cfg_data;
				tcc_pkg::REG_Y_GAIN:       cfg_q.y_gain       <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	assign adv3 = !valid_s3 || out_ch.ready;
	assign adv2 = !valid_s2 || adv3;
	assign adv1 = !valid_s1 || adv2;

	assign in_ch.ready = adv1;

	tcc_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.advance     (adv1),
		.valid       (in_ch.valid),
		.raw_x       (in_ch.raw_x),
		.raw_y       (in_ch.raw_y),
		.touch_flags (in_ch.touch_flags),
		.extra_word  (in_ch.extra_word),
		.cfg         (cfg_q),
		.valid_s1    (valid_s1),
		.data_s1     (data_s1)
	);

	tcc_mul u_mul (
		.clk      (clk),
		.arst_n   (arst_n),
		.advance  (adv2),
		.valid_s1 (valid_s1),
		.data_s1  (data_s1),
		.cfg      (cfg_q),
		.valid_s2 (valid_s2),
		.data_s2  (data_s2)
	);

	tcc_clamp u_clamp (
		.clk      (clk),
		.arst_n   (arst_n),
		.advance  (adv3),
		.valid_s2 (valid_s2),
		.data_s2  (data_s2),
		.valid_s3 (valid_s3),
		.data_s3  (data_s3)
	);

	assign out_ch.valid     = valid_s3;
	assign out_ch.screen_x  = data_s3.screen_x;
	assign out_ch.screen_y  = data_s3.screen_y;
	assign out_ch.flags_out = data_s3.flags_out;
	assign out_ch.extra_out = data_s3.extra_out;

endmodule

`default_nettype wire

// File: verif/touch_coordinate_calibrator_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// touch_coordinate_calibrator_tb
// Self-checking bench for the touch coordinate calibrator.
//
// Raw touch records are sent on the request channel under a series of
// calibration settings. These include pass-through, unit gain, extreme
// coefficients and random realistic mappings. A scoreboard predicts every
// calibrated result and compares it, in order, with what the block returns.
// Both channel ends idle in random bursts. The receiver also holds off once
// for a long stretch, so that the pipeline fills up and stalls its input.
// ----------------------------------------------------------------------------

module touch_coordinate_calibrator_tb;

	localparam logic [tcc_pkg::CfgIdxW-1:0] RegSpare = 3'd5;
	localparam int LongHold = 40;
	localparam int RandPhases = 12;
	localparam int PhaseItems = 127;
	localparam int DrainCycles = 8;
	localparam int ReportLimit = 10;

	typedef struct packed {
		logic [tcc_pkg::FieldW-1:0] raw_x;
		logic [tcc_pkg::FieldW-1:0] raw_y;
		logic [tcc_pkg::FieldW-1:0] touch_flags;
		logic [tcc_pkg::FieldW-1:0] extra_word;
	} touch_rec_t;

	typedef struct {
		logic [tcc_pkg::CoefW-1:0] enable_word;
		logic [tcc_pkg::CoefW-1:0] x_off;
		logic [tcc_pkg::CoefW-1:0] x_gain;
		logic [tcc_pkg::CoefW-1:0] y_off;
		logic [tcc_pkg::CoefW-1:0] y_gain;
	} calib_set_t;

	class screen_checker;
		logic                      calib_en;
		logic [tcc_pkg::CoefW-1:0] x_off;
		logic [tcc_pkg::CoefW-1:0] x_gain;
		logic [tcc_pkg::CoefW-1:0] y_off;
		logic [tcc_pkg::CoefW-1:0] y_gain;
		tcc_pkg::s3_t              expected_screen[$];
		int                        mismatches;

		function new();
			calib_en = 1'b0;
			x_off = '0;
			x_gain = '0;
			y_off = '0;
			y_gain = '0;
			mismatches = 0;
		endfunction

		function void set_reg(logic [tcc_pkg::CfgIdxW-1:0] idx,
				logic [tcc_pkg::CoefW-1:0] data);
			case (idx)
				tcc_pkg::REG_CALIB_ENABLE: calib_en = data[0];
				tcc_pkg::REG_X_OFFSET:     x_off = data;
				tcc_pkg::REG_X_GAIN:       x_gain = data;
				tcc_pkg::REG_Y_OFFSET:     y_off = data;
				tcc_pkg::REG_Y_GAIN:       y_gain = data;
				default: begin
				end
			endcase
		endfunction

		function logic [tcc_pkg::FieldW-1:0] scale_axis(logic [tcc_pkg::FieldW-1:0] raw,
				logic [tcc_pkg::CoefW-1:0] off, logic [tcc_pkg::CoefW-1:0] gain,
				logic [tcc_pkg::FieldW-1:0] limit);
			longint diff;
			longint prod;
			logic [tcc_pkg::FieldW-1:0] v;
			diff = longint'({raw, 2'b00}) - longint'($signed(off));
			prod = longint'($signed(gain)) * diff;
			v = prod[tcc_pkg::FracW +: tcc_pkg::FieldW];
			if (v[tcc_pkg::FieldW-1])
				return '0;
			if (v > limit)
				return limit;
			return v;
		endfunction

		function tcc_pkg::s3_t calibrate(touch_rec_t r);
			tcc_pkg::s3_t res;
			res.flags_out = r.touch_flags;
			res.extra_out = r.extra_word;
			if (!calib_en) begin
				res.screen_x = r.raw_x;
				res.screen_y = r.raw_y;
			end else if (r.touch_flags == '0) begin
				res.screen_x = '0;
				res.screen_y = '0;
			end else begin
				res.screen_x = scale_axis(r.raw_x, x_off, x_gain, tcc_pkg::XLimit);
				res.screen_y = scale_axis(r.raw_y, y_off, y_gain, tcc_pkg::YLimit);
			end
			return res;
		endfunction

		function void note_request(touch_rec_t r);
			expected_screen.push_back(calibrate(r));
		endfunction

		function void check_result(tcc_pkg::s3_t got);
			tcc_pkg::s3_t exp_res;
			if (expected_screen.size() == 0) begin
				mismatches++;
				if (mismatches <= ReportLimit)
					$display("unexpected result: x=%0d y=%0d flags=%h extra=%h",
						got.screen_x, got.screen_y, got.flags_out, got.extra_out);
				return;
			end
			exp_res = expected_screen.pop_front();
			if (got.screen_x !== exp_res.screen_x || got.screen_y !== exp_res.screen_y ||
					got.flags_out !== exp_res.flags_out ||
					got.extra_out !== exp_res.extra_out) begin
				mismatches++;
				if (mismatches <= ReportLimit) begin
					$write("mismatch: expected x=%0d y=%0d flags=%h extra=%h, ",
						exp_res.screen_x, exp_res.screen_y, exp_res.flags_out,
						exp_res.extra_out);
					$display("got x=%0d y=%0d flags=%h extra=%h",
						got.screen_x, got.screen_y, got.flags_out, got.extra_out);
				end
			end
		endfunction

		function int outstanding();
			return expected_screen.size();
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [tcc_pkg::CfgIdxW-1:0] cfg_index;
	logic [tcc_pkg::CoefW-1:0] cfg_data;

	bit tx_idle;
	bit rx_idle;
	bit rx_hold_req;
	int rx_stall_left;

	screen_checker chk;

	tcc_in_if in_ch ();
	tcc_out_if out_ch ();

	touch_coordinate_calibrator dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_ch     (in_ch),
		.out_ch    (out_ch),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#2_000_000;
		$display("TB_ERROR");
		$finish;
	end

	always @(posedge clk) begin
		if (arst_n && out_ch.valid && out_ch.ready)
			chk.check_result({out_ch.screen_x, out_ch.screen_y, out_ch.flags_out,
				out_ch.extra_out});
	end

	// Receiver: random short stalls, plus one long hold-off on request.
	initial begin
		rx_stall_left = 0;
		out_ch.ready <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (rx_hold_req) begin
				rx_hold_req = 1'b0;
				rx_stall_left = LongHold;
			end else if (rx_stall_left == 0 && rx_idle && $urandom_range(0, 5) == 0) begin
				rx_stall_left = $urandom_range(1, 4);
			end
			if (rx_stall_left > 0) begin
				out_ch.ready <= 1'b0;
				rx_stall_left--;
			end else begin
				out_ch.ready <= 1'b1;
			end
		end
	end

	task automatic write_reg(input logic [tcc_pkg::CfgIdxW-1:0] idx,
			input logic [tcc_pkg::CoefW-1:0] data);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		chk.set_reg(idx, data);
	endtask

	task automatic program_cfg(input calib_set_t s);
		logic [tcc_pkg::CfgIdxW-1:0] spare;
		int unsigned spare_pick;
		spare_pick = RegSpare + $urandom_range(0, 2);
		spare = spare_pick[tcc_pkg::CfgIdxW-1:0];
		write_reg(tcc_pkg::REG_CALIB_ENABLE, s.enable_word);
		write_reg(tcc_pkg::REG_X_OFFSET, s.x_off);
		write_reg(tcc_pkg::REG_X_GAIN, s.x_gain);
		write_reg(tcc_pkg::REG_Y_OFFSET, s.y_off);
		write_reg(tcc_pkg::REG_Y_GAIN, s.y_gain);
		// Writes past the last register must leave every setting untouched.
		write_reg(spare, $urandom);
		cfg_we <= 1'b0;
	endtask

	task automatic send_rec(input touch_rec_t r);
		in_ch.valid <= 1'b1;
		in_ch.raw_x <= r.raw_x;
		in_ch.raw_y <= r.raw_y;
		in_ch.touch_flags <= r.touch_flags;
		in_ch.extra_word <= r.extra_word;
		@(posedge clk);
		while (!in_ch.ready)
			@(posedge clk);
		chk.note_request(r);
		if (tx_idle && $urandom_range(0, 5) == 0) begin
			in_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
	endtask

	task automatic send_fields(input logic [tcc_pkg::FieldW-1:0] rx,
			input logic [tcc_pkg::FieldW-1:0] ry, input logic [tcc_pkg::FieldW-1:0] fl,
			input logic [tcc_pkg::FieldW-1:0] ex);
		send_rec({rx, ry, fl, ex});
	endtask

	task automatic wait_drained();
		in_ch.valid <= 1'b0;
		while (chk.outstanding() != 0)
			@(posedge clk);
	endtask

	function automatic logic [tcc_pkg::CoefW-1:0] pick_extreme();
		case ($urandom_range(0, 4))
			0: return 32'h8000_0000;
			1: return 32'h7fff_ffff;
			2: return 32'h0000_0000;
			3: return 32'hffff_ffff;
			default: return 32'h0040_0000;
		endcase
	endfunction

	function automatic calib_set_t random_set(input int kind);
		calib_set_t s;
		int g;
		s.enable_word = $urandom;
		s.enable_word[0] = (kind != 3);
		s.x_off = $urandom;
		s.x_gain = $urandom;
		s.y_off = $urandom;
		s.y_gain = $urandom;
		if (kind == 0) begin
			g = $urandom_range(2000, 8000);
			if ($urandom_range(0, 1)) begin
				s.x_gain = -g;
				s.x_off = 262140 + $urandom_range(0, 40000) - 20000;
			end else begin
				s.x_gain = g;
				s.x_off = $urandom_range(0, 40000) - 20000;
			end
			g = $urandom_range(2000, 8000);
			if ($urandom_range(0, 1)) begin
				s.y_gain = -g;
				s.y_off = 262140 + $urandom_range(0, 40000) - 20000;
			end else begin
				s.y_gain = g;
				s.y_off = $urandom_range(0, 40000) - 20000;
			end
		end else if (kind == 2) begin
			s.x_off = pick_extreme();
			s.x_gain = pick_extreme();
			s.y_off = pick_extreme();
			s.y_gain = pick_extreme();
		end
		return s;
	endfunction

	function automatic logic [tcc_pkg::FieldW-1:0] random_raw();
		logic [tcc_pkg::CoefW-1:0] w;
		w = $urandom;
		case ($urandom_range(0, 9))
			0: return '0;
			1: return '1;
			default: return w[tcc_pkg::FieldW-1:0];
		endcase
	endfunction

	function automatic touch_rec_t random_rec();
		touch_rec_t r;
		logic [tcc_pkg::CoefW-1:0] flags_w;
		logic [tcc_pkg::CoefW-1:0] extra_w;
		flags_w = $urandom;
		extra_w = $urandom;
		r.raw_x = random_raw();
		r.raw_y = random_raw();
		r.touch_flags = ($urandom_range(0, 7) == 0) ? '0 : flags_w[tcc_pkg::FieldW-1:0];
		r.extra_word = extra_w[tcc_pkg::FieldW-1:0];
		return r;
	endfunction

	initial begin
		calib_set_t s;
		chk = new();
		tx_idle = 1'b0;
		rx_idle = 1'b0;
		rx_hold_req = 1'b0;
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_index <= '0;
		cfg_data <= '0;
		in_ch.valid <= 1'b0;
		in_ch.raw_x <= '0;
		in_ch.raw_y <= '0;
		in_ch.touch_flags <= '0;
		in_ch.extra_word <= '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset settings leave calibration off.
		send_fields(16'h0000, 16'h0000, 16'h0000, 16'h0000);
		send_fields(16'hffff, 16'hffff, 16'hffff, 16'hffff);
		wait_drained();

		// Unit gain: screen value is raw times four, clamped per axis.
		s = '{32'h0000_0001, 32'h0, 32'h0040_0000, 32'h0, 32'h0040_0000};
		program_cfg(s);
		send_fields(16'd0, 16'd0, 16'h0001, 16'h1234);
		send_fields(16'd63, 16'd47, 16'h0001, 16'h0000);
		send_fields(16'd64, 16'd48, 16'h0002, 16'hffff);
		send_fields(16'hffff, 16'hffff, 16'h0000, 16'haaaa);
		send_fields(16'h2000, 16'h2000, 16'h8000, 16'h5555);
		send_fields(16'h4040, 16'h4030, 16'h0001, 16'h0001);
		send_fields(16'h4000, 16'h4000, 16'h0100, 16'h8000);
		send_fields(16'hffff, 16'hffff, 16'hffff, 16'hffff);
		wait_drained();

		s = '{32'h0000_0001, 32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff};
		program_cfg(s);
		send_fields(16'h0000, 16'h0000, 16'h0001, 16'h0000);
		send_fields(16'hffff, 16'hffff, 16'hffff, 16'hffff);
		send_fields(16'h8000, 16'h7fff, 16'h7fff, 16'h8000);
		wait_drained();

		s = '{32'hffff_ffff, 32'hffff_fe70, 32'h0040_0000, 32'h0000_0320, 32'h0040_0000};
		program_cfg(s);
		send_fields(16'd0, 16'd100, 16'h0004, 16'h0000);
		send_fields(16'd10, 16'd250, 16'h0008, 16'h0000);
		send_fields(16'd20, 16'd240, 16'h0010, 16'h0000);
		wait_drained();

		s = '{32'hffff_fffe, 32'h0000_1000, 32'h0040_0000, 32'h0000_1000, 32'h0040_0000};
		program_cfg(s);
		send_fields(16'h1234, 16'hfedc, 16'h0000, 16'h0f0f);
		send_fields(16'hffff, 16'h0000, 16'h0001, 16'hf0f0);
		wait_drained();

		for (int p = 0; p < RandPhases; p++) begin
			program_cfg(random_set(p % 4));
			tx_idle = (p != 2) && (p != RandPhases - 1) && ($urandom_range(0, 3) != 0);
			rx_idle = (p != RandPhases - 1) && ($urandom_range(0, 3) != 0);
			if (p == 2)
				rx_hold_req = 1'b1;
			for (int i = 0; i < PhaseItems; i++)
				send_rec(random_rec());
			wait_drained();
		end

		repeat (DrainCycles) @(posedge clk);
		if (chk.mismatches == 0 && chk.outstanding() == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

// File: files.f
rtl/core/tcc_pkg.sv
rtl/core/tcc_if.sv
rtl/core/tcc_front.sv
rtl/core/tcc_mul.sv
rtl/core/tcc_clamp.sv
rtl/core/touch_coordinate_calibrator.sv
verif/touch_coordinate_calibrator_tb.sv
